// ----- rtl/rgbsb_pkg.sv -----
// Package for the RGB status/error blink generator.
// Holds the beat payload types, command and register codes, colour codes
// and the channel-level lookup used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package rgbsb_pkg;

  // Command codes carried in the input beat.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_STATUS = 2'd1;
  localparam logic [1:0] CMD_ERROR  = 2'd2;
  localparam logic [1:0] CMD_OFF    = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_GAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PAUSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOLID_ON    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOLID_OFF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_ON   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_OFF  = 3'd7;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [2:0] MAX_BLINKS  = 3'd6;
  localparam logic [6:0] MAX_PERCENT = 7'd100;

  // Channel scale: floor(level * b / 100) == (b * level * 5243) >> 19 for b <= 100.
  localparam int unsigned SCALE_RECIP = 5243;
  localparam int unsigned SCALE_SHIFT = 19;
  localparam int unsigned SCALE_W     = 28;
  localparam logic [SCALE_W-1:0] MUL_FULL = SCALE_W'(255 * SCALE_RECIP);
  localparam logic [SCALE_W-1:0] MUL_105  = SCALE_W'(105 * SCALE_RECIP);
  localparam logic [SCALE_W-1:0] MUL_180  = SCALE_W'(180 * SCALE_RECIP);

  // Every colour the pixel can show.
  typedef enum logic [2:0] {
    COL_DARK    = 3'd0,
    COL_YELLOW  = 3'd1,
    COL_MAGENTA = 3'd2,
    COL_BLUE    = 3'd3,
    COL_WHITE   = 3'd4,
    COL_PINK    = 3'd5,
    COL_RED     = 3'd6
  } colour_e;

  // Unscaled level of one channel.
  typedef enum logic [1:0] {
    LVL_ZERO = 2'd0,
    LVL_FULL = 2'd1,
    LVL_105  = 2'd2,
    LVL_180  = 2'd3
  } level_e;

  typedef struct packed {
    level_e red;
    level_e green;
    level_e blue;
  } levels_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [2:0]  status_class;
    logic [2:0]  error_blinks;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       pixel_write;
    logic       error_active;
    logic       error_finished;
  } out_beat_t;

  function automatic colour_e class_colour(logic [2:0] cls);
    colour_e c;
    case (cls)
      3'd1:    c = COL_YELLOW;
      3'd2:    c = COL_MAGENTA;
      3'd3:    c = COL_BLUE;
      3'd4:    c = COL_WHITE;
      3'd5:    c = COL_PINK;
      default: c = COL_DARK;
    endcase
    return c;
  endfunction

  function automatic levels_t colour_levels(colour_e c);
    levels_t l;
    case (c)
      COL_YELLOW:  l = '{red: LVL_FULL, green: LVL_FULL, blue: LVL_ZERO};
      COL_MAGENTA: l = '{red: LVL_FULL, green: LVL_ZERO, blue: LVL_FULL};
      COL_BLUE:    l = '{red: LVL_ZERO, green: LVL_ZERO, blue: LVL_FULL};
      COL_WHITE:   l = '{red: LVL_FULL, green: LVL_FULL, blue: LVL_FULL};
      COL_PINK:    l = '{red: LVL_FULL, green: LVL_105,  blue: LVL_180};
      COL_RED:     l = '{red: LVL_FULL, green: LVL_ZERO, blue: LVL_ZERO};
      default:     l = '{red: LVL_ZERO, green: LVL_ZERO, blue: LVL_ZERO};
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rgb_status_blink_code_generator.sv -----
// Top level of the RGB status/error blink generator.
// Depends on rgbsb_pkg for payload types, codes and the colour lookup.
//
// Usage: each input beat is a tick (with the current millisecond time), a
// set-status, a set-error or an off command; every beat yields exactly one
// output beat with the brightness-scaled pixel colour, a pixel-write flag and
// the error status flags. Both channels use valid/stall; a beat moves on a
// rising edge with valid high and stall low.
// Path: an accepted beat lands in an input register, is processed by one
// pass of combinational logic and moves to the output register once that
// register is empty or is being read. Throughput is one beat per cycle while
// the receiver does not stall, set by that single register-to-register pass.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more beat; only then is in_stall_o raised.
// Configuration writes land on a plain write port and are taken at any edge
// with cfg_we_i high; write them only while no beat is in flight.
// Reset (rst_ni low, asynchronous) empties both registers, turns the pixel
// off and loads the configuration defaults. There is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rgb_status_blink_code_generator #(
  parameter int unsigned ERROR_LOOPS = 3
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire rgbsb_pkg::in_beat_t             in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output rgbsb_pkg::out_beat_t                 out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rgbsb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rgbsb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_STATUS = 2'd1,
    MODE_ERROR  = 2'd2
  } mode_e;

  typedef struct packed {
    rgbsb_pkg::colour_e col;
    logic               wr;
  } shown_t;

  localparam logic [3:0] LOOPS = 4'(ERROR_LOOPS);

  // Move the shown colour and flag a pixel write when it really changes.
  function automatic shown_t show(shown_t cur, rgbsb_pkg::colour_e c);
    shown_t r;
    r = cur;
    if (c != cur.col) begin
      r.col = c;
      r.wr  = 1'b1;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [6:0]  brightness_q;
  logic [15:0] blink_on_q, blink_gap_q, blink_pause_q;
  logic [15:0] solid_on_q, solid_off_q, status_on_q, status_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q  <= 7'd25;
      blink_on_q    <= 16'd200;
      blink_gap_q   <= 16'd200;
      blink_pause_q <= 16'd1000;
      solid_on_q    <= 16'd2000;
      solid_off_q   <= 16'd1000;
      status_on_q   <= 16'd250;
      status_off_q  <= 16'd1750;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rgbsb_pkg::REG_BRIGHTNESS:  brightness_q  <= cfg_data_i[6:0];
        rgbsb_pkg::REG_BLINK_ON:    blink_on_q    <= cfg_data_i;
        rgbsb_pkg::REG_BLINK_GAP:   blink_gap_q   <= cfg_data_i;
        rgbsb_pkg::REG_BLINK_PAUSE: blink_pause_q <= cfg_data_i;
        rgbsb_pkg::REG_SOLID_ON:    solid_on_q    <= cfg_data_i;
        rgbsb_pkg::REG_SOLID_OFF:   solid_off_q   <= cfg_data_i;
        rgbsb_pkg::REG_STATUS_ON:   status_on_q   <= cfg_data_i;
        rgbsb_pkg::REG_STATUS_OFF:  status_off_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Scaled channel levels, refreshed every cycle from the brightness register.
  logic [6:0] bright_clamp;
  logic [rgbsb_pkg::SCALE_W-1:0] prod_full, prod_105, prod_180;
  logic [7:0] s_full_q, s_105_q, s_180_q;

  assign bright_clamp = (brightness_q > rgbsb_pkg::MAX_PERCENT) ?
                        rgbsb_pkg::MAX_PERCENT : brightness_q;
  assign prod_full = rgbsb_pkg::SCALE_W'(bright_clamp) * rgbsb_pkg::MUL_FULL;
  assign prod_105  = rgbsb_pkg::SCALE_W'(bright_clamp) * rgbsb_pkg::MUL_105;
  assign prod_180  = rgbsb_pkg::SCALE_W'(bright_clamp) * rgbsb_pkg::MUL_180;

  always_ff @(posedge clk_i) begin
    s_full_q <= prod_full[rgbsb_pkg::SCALE_SHIFT +: 8];
    s_105_q  <= prod_105[rgbsb_pkg::SCALE_SHIFT +: 8];
    s_180_q  <= prod_180[rgbsb_pkg::SCALE_SHIFT +: 8];
  end

  // Input register and handshake.
  logic                in_valid_q;
  rgbsb_pkg::in_beat_t in_q;
  logic                in_accept, advance;
  logic                out_valid_q;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // Block state.
  mode_e              mode_q, mode_d;
  logic [2:0]         active_class_q, active_class_d;
  logic               status_on_ph_q, status_on_ph_d;
  logic [2:0]         blink_index_q, blink_index_d;
  logic               error_on_ph_q, error_on_ph_d;
  logic [3:0]         loop_count_q, loop_count_d;
  logic               loops_done_q, loops_done_d;
  logic [2:0]         target_q, target_d;
  logic [31:0]        phase_start_q, phase_start_d;
  rgbsb_pkg::colour_e shown_q;
  shown_t             sh;

  logic [31:0]        elapsed;
  logic               lit, last_blink;
  rgbsb_pkg::colour_e class_col;

  assign elapsed    = in_q.now_ms - phase_start_q;
  assign lit        = (shown_q != rgbsb_pkg::COL_DARK);
  assign class_col  = rgbsb_pkg::class_colour(active_class_q);
  assign last_blink = (blink_index_q >= target_q - 3'd1);

  always_comb begin
    mode_d         = mode_q;
    active_class_d = active_class_q;
    status_on_ph_d = status_on_ph_q;
    blink_index_d  = blink_index_q;
    error_on_ph_d  = error_on_ph_q;
    loop_count_d   = loop_count_q;
    loops_done_d   = loops_done_q;
    target_d       = target_q;
    phase_start_d  = phase_start_q;
    sh             = '{col: shown_q, wr: 1'b0};

    case (in_q.cmd)
      rgbsb_pkg::CMD_TICK: begin
        case (mode_q)
          MODE_ERROR: begin
            if (loops_done_q) begin
              if (lit) sh = show(sh, rgbsb_pkg::COL_DARK);
            end else if (target_q == 3'd0) begin
              if (error_on_ph_q) begin
                sh = show(sh, rgbsb_pkg::COL_RED);
                if (elapsed >= 32'(solid_on_q)) begin
                  error_on_ph_d = 1'b0;
                  phase_start_d = in_q.now_ms;
                  sh = show(sh, rgbsb_pkg::COL_DARK);
                end
              end else begin
                sh = show(sh, rgbsb_pkg::COL_DARK);
                if (elapsed >= 32'(solid_off_q)) begin
                  error_on_ph_d = 1'b1;
                  phase_start_d = in_q.now_ms;
                  loop_count_d  = loop_count_q + 4'd1;
                  if (loop_count_d >= LOOPS) loops_done_d = 1'b1;
                end
              end
            end else if (error_on_ph_q) begin
              sh = show(sh, rgbsb_pkg::COL_RED);
              if (elapsed >= 32'(blink_on_q)) begin
                error_on_ph_d = 1'b0;
                phase_start_d = in_q.now_ms;
                sh = show(sh, rgbsb_pkg::COL_DARK);
              end
            end else begin
              sh = show(sh, rgbsb_pkg::COL_DARK);
              if (elapsed >= 32'(last_blink ? blink_pause_q : blink_gap_q)) begin
                if (last_blink) begin
                  loop_count_d = loop_count_q + 4'd1;
                  if (loop_count_d >= LOOPS) loops_done_d = 1'b1;
                  blink_index_d = 3'd0;
                end else begin
                  blink_index_d = blink_index_q + 3'd1;
                end
                // Start the next blink unless the last loop just ended.
                if (!loops_done_d) begin
                  error_on_ph_d = 1'b1;
                  phase_start_d = in_q.now_ms;
                  sh = show(sh, rgbsb_pkg::COL_RED);
                end else begin
                  blink_index_d = blink_index_q;
                end
              end
            end
          end
          MODE_STATUS: begin
            if (status_on_ph_q) begin
              sh = show(sh, class_col);
              if (elapsed >= 32'(status_on_q)) begin
                status_on_ph_d = 1'b0;
                phase_start_d  = in_q.now_ms;
                sh = show(sh, rgbsb_pkg::COL_DARK);
              end
            end else begin
              sh = show(sh, rgbsb_pkg::COL_DARK);
              if (elapsed >= 32'(status_off_q)) begin
                status_on_ph_d = 1'b1;
                phase_start_d  = in_q.now_ms;
                sh = show(sh, class_col);
              end
            end
          end
          default: begin
            if (lit) sh = show(sh, rgbsb_pkg::COL_DARK);
          end
        endcase
      end
      rgbsb_pkg::CMD_STATUS: begin
        if (mode_q != MODE_STATUS || active_class_q != in_q.status_class) begin
          mode_d         = MODE_STATUS;
          active_class_d = in_q.status_class;
          status_on_ph_d = 1'b0;
          blink_index_d  = 3'd0;
          error_on_ph_d  = 1'b0;
          phase_start_d  = in_q.now_ms;
        end
      end
      rgbsb_pkg::CMD_ERROR: begin
        mode_d        = MODE_ERROR;
        target_d      = (in_q.error_blinks > rgbsb_pkg::MAX_BLINKS) ?
                        rgbsb_pkg::MAX_BLINKS : in_q.error_blinks;
        blink_index_d = 3'd0;
        error_on_ph_d = 1'b1;
        loop_count_d  = 4'd0;
        loops_done_d  = 1'b0;
        phase_start_d = in_q.now_ms;
      end
      default: begin
        sh             = show(sh, rgbsb_pkg::COL_DARK);
        mode_d         = MODE_OFF;
        status_on_ph_d = 1'b0;
        blink_index_d  = 3'd0;
        error_on_ph_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_OFF;
      active_class_q <= 3'd0;
      status_on_ph_q <= 1'b0;
      blink_index_q  <= 3'd0;
      error_on_ph_q  <= 1'b0;
      loop_count_q   <= 4'd0;
      loops_done_q   <= 1'b0;
      target_q       <= 3'd0;
      phase_start_q  <= 32'd0;
      shown_q        <= rgbsb_pkg::COL_DARK;
    end else if (advance) begin
      mode_q         <= mode_d;
      active_class_q <= active_class_d;
      status_on_ph_q <= status_on_ph_d;
      blink_index_q  <= blink_index_d;
      error_on_ph_q  <= error_on_ph_d;
      loop_count_q   <= loop_count_d;
      loops_done_q   <= loops_done_d;
      target_q       <= target_d;
      phase_start_q  <= phase_start_d;
      shown_q        <= sh.col;
    end
  end

  // Output register: colour code and flags; scaling is applied on the way out.
  rgbsb_pkg::colour_e out_col_q;
  logic               out_wr_q, out_err_q, out_fin_q;
  rgbsb_pkg::levels_t lv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_col_q <= sh.col;
      out_wr_q  <= sh.wr;
      out_err_q <= (mode_d == MODE_ERROR);
      out_fin_q <= loops_done_d;
    end
  end

  function automatic logic [7:0] pick(rgbsb_pkg::level_e l, logic [7:0] sf,
                                      logic [7:0] s105, logic [7:0] s180);
    logic [7:0] v;
    case (l)
      rgbsb_pkg::LVL_FULL: v = sf;
      rgbsb_pkg::LVL_105:  v = s105;
      rgbsb_pkg::LVL_180:  v = s180;
      default:             v = 8'd0;
    endcase
    return v;
  endfunction

  assign lv          = rgbsb_pkg::colour_levels(out_col_q);
  assign out_valid_o = out_valid_q;

  always_comb begin
    out_data_o.pixel_red      = pick(lv.red, s_full_q, s_105_q, s_180_q);
    out_data_o.pixel_green    = pick(lv.green, s_full_q, s_105_q, s_180_q);
    out_data_o.pixel_blue     = pick(lv.blue, s_full_q, s_105_q, s_180_q);
    out_data_o.pixel_write    = out_wr_q;
    out_data_o.error_active   = out_err_q;
    out_data_o.error_finished = out_fin_q;
  end

  // A processed beat always lands in the output register.
  a_advance_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed beat did not reach the output register");

  // Stall only while a beat is held in the input register.
  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a held beat");

  // Status mode never carries an error phase.
  a_status_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_STATUS) |-> !error_on_ph_q)
    else $error("error phase set in status mode");

  // Blink index stays below the largest blink count, and the target never exceeds it.
  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blink_index_q < rgbsb_pkg::MAX_BLINKS) && (target_q <= rgbsb_pkg::MAX_BLINKS))
    else $error("blink index or target out of range");

endmodule

`default_nettype wire

// ----- verif/blink_checker.sv -----
// Checker for the RGB status/error blink generator: keeps its own copy of the
// pixel state and settings, predicts one pixel beat per command beat and compares.
// Depends on rgbsb_pkg for the beat types, command, register and colour codes.
`timescale 1ns / 1ps

module blink_checker #(
  parameter int unsigned ERROR_LOOPS = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  rgbsb_pkg::in_beat_t             in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  rgbsb_pkg::out_beat_t            out_data_i,
  input  logic                            cfg_we_i,
  input  logic [rgbsb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgbsb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              pending_o,
  output int                              fail_count_o
);
  import rgbsb_pkg::*;

  typedef enum logic [1:0] {
    MD_OFF    = 2'd0,
    MD_STATUS = 2'd1,
    MD_ERROR  = 2'd2
  } mode_e;

  localparam logic [23:0] RGB_RED = 24'hFF0000;

  // settings
  logic [6:0]  pct;
  logic [15:0] t_blink_on, t_blink_gap, t_blink_pause;
  logic [15:0] t_solid_on, t_solid_off, t_stat_on, t_stat_off;

  // pixel state
  mode_e       mode;
  logic [2:0]  cls_now, blink_idx, n_blinks;
  logic        stat_on, err_on, done, lit, wrote;
  logic [3:0]  loops;
  logic [31:0] t_phase;
  logic [23:0] rgb;

  out_beat_t   pending_pixels[$];
  out_beat_t   want;

  function automatic void paint(input logic [23:0] c);
    if (c != rgb) begin
      rgb = c;
      wrote = 1'b1;
    end
    lit = (c != '0);
  endfunction

  function automatic logic [7:0] dim(input logic [7:0] level);
    logic [15:0] prod;
    prod = level * ((pct > MAX_PERCENT) ? MAX_PERCENT : pct);
    return 8'(prod / 16'd100);
  endfunction

  function automatic void close_loop();
    loops = loops + 4'd1;
    if (loops >= ERROR_LOOPS) done = 1'b1;
  endfunction

  function automatic void err_tick(input logic [31:0] now, input logic [31:0] el);
    logic last;
    if (done) begin
      if (lit) paint('0);
      return;
    end
    if (n_blinks == 3'd0) begin
      // solid pattern: one long red, one long dark per loop
      if (err_on) begin
        paint(RGB_RED);
        if (el >= t_solid_on) begin
          err_on = 1'b0;
          t_phase = now;
          paint('0);
        end
      end else begin
        paint('0);
        if (el >= t_solid_off) begin
          err_on = 1'b1;
          t_phase = now;
          close_loop();
        end
      end
      return;
    end
    if (err_on) begin
      paint(RGB_RED);
      if (el >= t_blink_on) begin
        err_on = 1'b0;
        t_phase = now;
        paint('0);
      end
    end else begin
      last = (blink_idx >= n_blinks - 3'd1);
      paint('0);
      if (el >= (last ? t_blink_pause : t_blink_gap)) begin
        if (last) begin
          close_loop();
          if (done) begin
            paint('0);
            return;
          end
          blink_idx = 3'd0;
        end else begin
          blink_idx = blink_idx + 3'd1;
        end
        err_on = 1'b1;
        t_phase = now;
        paint(RGB_RED);
      end
    end
  endfunction

  function automatic void status_tick(input logic [31:0] now, input logic [31:0] el);
    logic [23:0] c;
    // class numbers line up with the colour codes; anything else is dark
    case (colour_e'(cls_now))
      COL_YELLOW:  c = 24'hFFFF00;
      COL_MAGENTA: c = 24'hFF00FF;
      COL_BLUE:    c = 24'h0000FF;
      COL_WHITE:   c = 24'hFFFFFF;
      COL_PINK:    c = 24'hFF69B4;
      default:     c = 24'h000000;
    endcase
    if (stat_on) begin
      paint(c);
      if (el >= t_stat_on) begin
        stat_on = 1'b0;
        t_phase = now;
        paint('0);
      end
    end else begin
      paint('0);
      if (el >= t_stat_off) begin
        stat_on = 1'b1;
        t_phase = now;
        paint(c);
      end
    end
  endfunction

  function automatic out_beat_t next_pixel(input in_beat_t b);
    out_beat_t   r;
    logic [31:0] el;
    el = b.now_ms - t_phase;
    wrote = 1'b0;
    case (b.cmd)
      CMD_TICK: begin
        if (mode == MD_ERROR) err_tick(b.now_ms, el);
        else if (mode == MD_STATUS) status_tick(b.now_ms, el);
        else if (lit) paint('0);
      end
      CMD_STATUS: begin
        // same class again keeps the running blink
        if (mode != MD_STATUS || cls_now != b.status_class) begin
          mode = MD_STATUS;
          cls_now = b.status_class;
          stat_on = 1'b0;
          blink_idx = 3'd0;
          err_on = 1'b0;
          t_phase = b.now_ms;
        end
      end
      CMD_ERROR: begin
        mode = MD_ERROR;
        n_blinks = (b.error_blinks > MAX_BLINKS) ? MAX_BLINKS : b.error_blinks;
        blink_idx = 3'd0;
        err_on = 1'b1;
        loops = 4'd0;
        done = 1'b0;
        t_phase = b.now_ms;
      end
      CMD_OFF: begin
        paint('0);
        mode = MD_OFF;
        stat_on = 1'b0;
        blink_idx = 3'd0;
        err_on = 1'b0;
      end
    endcase
    r.pixel_red      = dim(rgb[23:16]);
    r.pixel_green    = dim(rgb[15:8]);
    r.pixel_blue     = dim(rgb[7:0]);
    r.pixel_write    = wrote;
    r.error_active   = (mode == MD_ERROR);
    r.error_finished = done;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      fail_count_o++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct = 7'd25;
      t_blink_on = 16'd200;
      t_blink_gap = 16'd200;
      t_blink_pause = 16'd1000;
      t_solid_on = 16'd2000;
      t_solid_off = 16'd1000;
      t_stat_on = 16'd250;
      t_stat_off = 16'd1750;
      mode = MD_OFF;
      cls_now = '0;
      stat_on = 1'b0;
      blink_idx = '0;
      err_on = 1'b0;
      loops = '0;
      done = 1'b0;
      n_blinks = '0;
      t_phase = '0;
      rgb = '0;
      lit = 1'b0;
      wrote = 1'b0;
      pending_pixels.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      // compare first: a beat taken at this edge cannot come out at the same one
      if (out_valid_i && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          fail_count_o++;
          $display("%0t: pixel beat %h arrived with none expected", $time, out_data_i);
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_red", want.pixel_red, out_data_i.pixel_red);
          check_field("pixel_green", want.pixel_green, out_data_i.pixel_green);
          check_field("pixel_blue", want.pixel_blue, out_data_i.pixel_blue);
          check_field("pixel_write", 8'(want.pixel_write),
                      8'(out_data_i.pixel_write));
          check_field("error_active", 8'(want.error_active),
                      8'(out_data_i.error_active));
          check_field("error_finished", 8'(want.error_finished),
                      8'(out_data_i.error_finished));
        end
      end
      if (in_valid_i && !in_stall_i) pending_pixels.push_back(next_pixel(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BRIGHTNESS:  pct = cfg_data_i[6:0];
          REG_BLINK_ON:    t_blink_on = cfg_data_i;
          REG_BLINK_GAP:   t_blink_gap = cfg_data_i;
          REG_BLINK_PAUSE: t_blink_pause = cfg_data_i;
          REG_SOLID_ON:    t_solid_on = cfg_data_i;
          REG_SOLID_OFF:   t_solid_off = cfg_data_i;
          REG_STATUS_ON:   t_stat_on = cfg_data_i;
          REG_STATUS_OFF:  t_stat_off = cfg_data_i;
        endcase
      end
      pending_o <= pending_pixels.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the blink generator testbench: clock, reset, command and setting
// stimulus, output stalls and the verdict. Needs rgbsb_pkg, the block and blink_checker.
`timescale 1ns / 1ps

module testbench;
  import rgbsb_pkg::*;

  localparam int unsigned LOOPS = 3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid, in_stall;
  in_beat_t              in_data;
  logic                  out_valid, out_stall;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_req;
  logic                  no_gaps = 1'b0;
  logic [31:0]           t_ms;
  int                    pending, fail_count;

  always #5 clk = ~clk;

  rgb_status_blink_code_generator #(.ERROR_LOOPS(LOOPS)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  blink_checker #(.ERROR_LOOPS(LOOPS)) check_u (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic in_beat_t beat(input logic [1:0] op, input logic [31:0] now,
                                    input logic [2:0] cls, input logic [2:0] nb);
    in_beat_t b;
    b.cmd = op;
    b.now_ms = now;
    b.status_class = cls;
    b.error_blinks = nb;
    return b;
  endfunction

  // Offer one beat, hold it until taken, then maybe idle a while.
  task automatic send_beat(input in_beat_t b);
    int r;
    int gap;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected pixel beat has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [6:0] pct, input logic [15:0] b_on,
                           input logic [15:0] b_gap, input logic [15:0] b_pause,
                           input logic [15:0] s_on, input logic [15:0] s_off,
                           input logic [15:0] st_on, input logic [15:0] st_off);
    put_reg(REG_BRIGHTNESS, {9'd0, pct});
    put_reg(REG_BLINK_ON, b_on);
    put_reg(REG_BLINK_GAP, b_gap);
    put_reg(REG_BLINK_PAUSE, b_pause);
    put_reg(REG_SOLID_ON, s_on);
    put_reg(REG_SOLID_OFF, s_off);
    put_reg(REG_STATUS_ON, st_on);
    put_reg(REG_STATUS_OFF, st_off);
    cfg_we <= 1'b0;
  endtask

  // Mode command followed by a run of ticks with advancing time; some noise mixed in.
  task automatic random_phase(input int n, input int unsigned step_hi);
    int       sent_n;
    int       r;
    in_beat_t b;
    sent_n = 0;
    while (sent_n < n) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r >= 88) t_ms = $urandom();
      b = beat(CMD_TICK, t_ms, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      if (r < 45) b.cmd = CMD_ERROR;
      else if (r < 80) b.cmd = CMD_STATUS;
      else if (r < 88) b.cmd = CMD_OFF;
      send_beat(b);
      sent_n++;
      repeat ($urandom_range(2, 24)) begin
        if ($urandom_range(0, 19) == 0) t_ms = t_ms + $urandom();
        else t_ms = t_ms + $urandom_range(0, step_hi);
        b = beat(CMD_TICK, t_ms, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 29) == 0) b.cmd = CMD_STATUS + 2'($urandom_range(0, 2));
        send_beat(b);
        sent_n++;
        if ($urandom_range(0, 79) == 0) wait_idle();
      end
    end
    no_gaps = 1'b0;
  endtask

  // Output side: short and long stalls, stall-free stretches, one long hold-off.
  initial begin
    int busy;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (64) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 15) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 150)) @(posedge clk);
      end else begin
        busy = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (busy) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    hold_req <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // power-on settings: walk through every command and the odd cases
    send_beat(beat(CMD_TICK, 32'd0, 3'd0, 3'd0));
    send_beat(beat(CMD_STATUS, 32'd0, COL_YELLOW, 3'd0));
    send_beat(beat(CMD_TICK, 32'd100, 3'd0, 3'd0));
    send_beat(beat(CMD_TICK, 32'd1750, 3'd0, 3'd0));
    send_beat(beat(CMD_TICK, 32'd1800, 3'd0, 3'd0));
    send_beat(beat(CMD_STATUS, 32'd1900, COL_YELLOW, 3'd0));
    send_beat(beat(CMD_TICK, 32'd2000, 3'd0, 3'd0));
    send_beat(beat(CMD_STATUS, 32'd2000, COL_PINK, 3'd0));
    send_beat(beat(CMD_TICK, 32'd3750, 3'd0, 3'd0));
    // unknown classes show dark
    send_beat(beat(CMD_STATUS, 32'd4000, 3'd6, 3'd0));
    send_beat(beat(CMD_TICK, 32'd5750, 3'd0, 3'd0));
    send_beat(beat(CMD_STATUS, 32'hFFFF_FF00, 3'd7, 3'd0));
    send_beat(beat(CMD_TICK, 32'h0000_0700, 3'd0, 3'd0));
    // elapsed time across the counter wrap
    send_beat(beat(CMD_STATUS, 32'hFFFF_FFFF, COL_WHITE, 3'd0));
    send_beat(beat(CMD_TICK, 32'h0000_06D6, 3'd0, 3'd0));
    // seven blinks clamp to six
    send_beat(beat(CMD_ERROR, 32'd5000, 3'd0, 3'd7));
    send_beat(beat(CMD_TICK, 32'd5000, 3'd0, 3'd0));
    send_beat(beat(CMD_TICK, 32'd5200, 3'd0, 3'd0));
    send_beat(beat(CMD_TICK, 32'd5400, 3'd0, 3'd0));
    send_beat(beat(CMD_OFF, 32'd0, 3'd0, 3'd0));
    // solid red pattern
    send_beat(beat(CMD_ERROR, 32'd10000, 3'd0, 3'd0));
    send_beat(beat(CMD_TICK, 32'd10000, 3'd0, 3'd0));
    send_beat(beat(CMD_TICK, 32'd12000, 3'd0, 3'd0));
    send_beat(beat(CMD_TICK, 32'd13000, 3'd0, 3'd0));
    send_beat(beat(CMD_OFF, 32'd13000, 3'd0, 3'd0));
    t_ms = 32'd20000;

    wait_idle();
    load_regs(7'd100, 16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
              16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
              16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
              16'($urandom_range(1, 12)));
    // hold the output long enough to back up the input
    hold_req <= 1'b1;
    random_phase(180, 8);

    wait_idle();
    load_regs(7'd0, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
              16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
              16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
              16'($urandom_range(0, 3)));
    random_phase(180, 3);

    wait_idle();
    load_regs(7'd127, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    // zero phase times: red then dark within one tick
    send_beat(beat(CMD_ERROR, t_ms, 3'd0, 3'd3));
    send_beat(beat(CMD_TICK, t_ms, 3'd0, 3'd0));
    send_beat(beat(CMD_STATUS, t_ms, COL_WHITE, 3'd0));
    send_beat(beat(CMD_TICK, t_ms, 3'd0, 3'd0));
    send_beat(beat(CMD_TICK, t_ms, 3'd0, 3'd0));
    random_phase(180, 2);

    wait_idle();
    load_regs(7'd100, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    random_phase(180, 21847);

    wait_idle();
    load_regs(7'($urandom_range(1, 99)), 16'($urandom_range(0, 20)),
              16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
              16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
              16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)));
    random_phase(180, 14);

    in_valid <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 20000 && pending != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
